// ===== sv/utfd_pkg.sv =====
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// Holds the channel payload structs, the request plan format and the marker text.
// No dependencies.
package utfd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
  } out_t;

  // Fixed result slots of one request, emitted in slot order.
  localparam int NUM_SLOTS = 9;
  typedef logic [3:0] slot_idx_t;

  localparam slot_idx_t SLOT_OLD_LEAD   = 4'd0;
  localparam slot_idx_t SLOT_OLD_SECOND = 4'd1;
  localparam slot_idx_t SLOT_OLD_MARK   = 4'd2;
  localparam slot_idx_t SLOT_VALUE      = 4'd3;
  localparam slot_idx_t SLOT_VALUE_MARK = 4'd4;
  localparam slot_idx_t SLOT_LAST_LEAD  = 4'd5;
  localparam slot_idx_t SLOT_LAST_SECOND = 4'd6;
  localparam slot_idx_t SLOT_LAST_MARK  = 4'd7;
  localparam slot_idx_t SLOT_TERM       = 4'd8;

  localparam int MARK_LEN = 8;
  typedef logic [2:0] mark_idx_t;
  localparam mark_idx_t MARK_LAST = 3'd7;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] vld;
    logic [7:0]           old_lead;
    logic [7:0]           old_second;
    logic [15:0]          value;
    logic [7:0]           new_lead;
    logic [7:0]           new_second;
  } plan_t;

  // Characters of "<BADUTF>".
  function automatic logic [15:0] marker_char(input mark_idx_t idx);
    logic [15:0] ch;
    case (idx)
      3'd0:    ch = 16'h003C;
      3'd1:    ch = 16'h0042;
      3'd2:    ch = 16'h0041;
      3'd3:    ch = 16'h0044;
      3'd4:    ch = 16'h0055;
      3'd5:    ch = 16'h0054;
      3'd6:    ch = 16'h0046;
      default: ch = 16'h003E;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/utfd_decode.sv =====
// Byte classifier and held-sequence state for the UTF-8 decoder.
// Turns one request into a slot plan and updates the held lead/continuation bytes.
// Depends on utfd_pkg.
module utfd_decode
  import utfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  logic  accept,
  output plan_t plan
);

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  logic [7:0] held_lead_r, held_lead_nxt;
  logic [7:0] held_second_r, held_second_nxt;
  logic [1:0] held_count_r, held_count_nxt;

  logic [7:0] b;
  logic       cont;
  logic       fresh;

  always_comb begin
    b               = in_data.data_byte;
    cont            = (b[7:6] == 2'b10);
    fresh           = 1'b0;
    plan            = '0;
    held_lead_nxt   = held_lead_r;
    held_second_nxt = held_second_r;
    held_count_nxt  = held_count_r;

    case (held_count_r)
      HELD_NONE: begin
        fresh = 1'b1;
      end
      HELD_ONE: begin
        if (cont && (held_lead_r < 8'hE0)) begin
          plan.value              = {5'b0, held_lead_r[4:0], b[5:0]};
          plan.vld[SLOT_VALUE]    = 1'b1;
          held_count_nxt          = HELD_NONE;
          held_lead_nxt           = '0;
        end else if (cont) begin
          held_second_nxt = b;
          held_count_nxt  = HELD_TWO;
        end else begin
          plan.old_lead           = held_lead_r;
          plan.vld[SLOT_OLD_LEAD] = 1'b1;
          plan.vld[SLOT_OLD_MARK] = 1'b1;
          fresh                   = 1'b1;
        end
      end
      default: begin
        // two held bytes; an unused count of three acts the same
        if (cont) begin
          plan.value           = {held_lead_r[3:0], held_second_r[5:0], b[5:0]};
          plan.vld[SLOT_VALUE] = 1'b1;
          held_count_nxt       = HELD_NONE;
          held_lead_nxt        = '0;
          held_second_nxt      = '0;
        end else begin
          plan.old_lead             = held_lead_r;
          plan.old_second           = held_second_r;
          plan.vld[SLOT_OLD_LEAD]   = 1'b1;
          plan.vld[SLOT_OLD_SECOND] = 1'b1;
          plan.vld[SLOT_OLD_MARK]   = 1'b1;
          fresh                     = 1'b1;
        end
      end
    endcase

    if (fresh) begin
      held_count_nxt  = HELD_NONE;
      held_lead_nxt   = '0;
      held_second_nxt = '0;
      if (b < 8'h80) begin
        plan.value           = {8'h00, b};
        plan.vld[SLOT_VALUE] = 1'b1;
      end else if (b inside {[8'hC0:8'hEF]}) begin
        held_lead_nxt  = b;
        held_count_nxt = HELD_ONE;
      end else begin
        plan.value                = {8'h00, b};
        plan.vld[SLOT_VALUE]      = 1'b1;
        plan.vld[SLOT_VALUE_MARK] = 1'b1;
      end
    end

    // end of string: flush whatever is still held, then terminate
    if (in_data.is_last) begin
      if (held_count_nxt != HELD_NONE) begin
        plan.new_lead            = held_lead_nxt;
        plan.new_second          = held_second_nxt;
        plan.vld[SLOT_LAST_LEAD] = 1'b1;
        plan.vld[SLOT_LAST_SECOND] = (held_count_nxt != HELD_ONE);
        plan.vld[SLOT_LAST_MARK] = 1'b1;
      end
      plan.vld[SLOT_TERM] = 1'b1;
      held_count_nxt      = HELD_NONE;
      held_lead_nxt       = '0;
      held_second_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r  <= HELD_NONE;
      held_lead_r   <= '0;
      held_second_r <= '0;
    end else if (accept) begin
      held_count_r  <= held_count_nxt;
      held_lead_r   <= held_lead_nxt;
      held_second_r <= held_second_nxt;
    end
  end

endmodule

// ===== sv/utfd_emit.sv =====
// Result sequencer for the UTF-8 decoder; it feeds the output register.
// Walks the registered slot plan one code unit a cycle unless out_ready stalls.
// Depends on utfd_pkg.
module utfd_emit
  import utfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  plan_t plan,
  input  logic  load,
  output logic  load_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  plan_t              plan_r;
  logic [NUM_SLOTS-1:0] rem_r, rem_nxt;
  mark_idx_t          sub_r, sub_nxt;
  logic               out_valid_r;
  out_t               out_data_r;

  slot_idx_t          cur;
  logic               is_mark;
  logic               slot_done;
  logic [NUM_SLOTS-1:0] rem_after;
  logic               unit_last;
  logic               have;
  logic               step;
  out_t               unit;

  always_comb begin
    cur = SLOT_OLD_LEAD;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem_r[i]) cur = slot_idx_t'(i);
    end
  end

  always_comb begin
    is_mark   = (cur == SLOT_OLD_MARK) || (cur == SLOT_VALUE_MARK) ||
                (cur == SLOT_LAST_MARK);
    slot_done = !is_mark || (sub_r == MARK_LAST);
    rem_after = rem_r;
    if (slot_done) rem_after[cur] = 1'b0;
    unit_last = slot_done && (rem_after == '0);
    have      = |rem_r;
    step      = have && (!out_valid_r || out_ready);
    load_ready = !have || (step && unit_last);
  end

  always_comb begin
    unit            = '0;
    unit.run_last   = unit_last;
    case (cur)
      SLOT_OLD_LEAD:    unit.code_unit = {8'h00, plan_r.old_lead};
      SLOT_OLD_SECOND:  unit.code_unit = {8'h00, plan_r.old_second};
      SLOT_VALUE:       unit.code_unit = plan_r.value;
      SLOT_LAST_LEAD:   unit.code_unit = {8'h00, plan_r.new_lead};
      SLOT_LAST_SECOND: unit.code_unit = {8'h00, plan_r.new_second};
      SLOT_TERM: begin
        unit.code_unit  = '0;
        unit.string_end = 1'b1;
      end
      default:          unit.code_unit = marker_char(sub_r);
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    sub_nxt = sub_r;
    if (step) begin
      rem_nxt = rem_after;
      sub_nxt = slot_done ? mark_idx_t'(0) : sub_r + mark_idx_t'(1);
    end
    // a new request replaces the plan once its last unit goes out
    if (load) begin
      rem_nxt = plan.vld;
      sub_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      sub_r <= sub_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) plan_r <= plan;
    if (step) out_data_r <= unit;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/utf8_decoder_with_error_marker.sv =====
// Top level of the UTF-8 to 16-bit code unit decoder with "<BADUTF>" error marker.
// Instantiates utfd_decode (classify, held state) and utfd_emit (sequencer, output reg).
// Depends on utfd_pkg.
//
//   Channel | Ports                        | Direction | Payload
//   --------+------------------------------+-----------+-------------------------------
//   in      | in_valid, in_ready, in_data  | into      | data_byte, is_last
//   out     | out_valid, out_ready, out_data | out of  | code_unit, run_last, string_end
//
// One code unit leaves per cycle while out_ready does not stall; a request yields 0 to
// 20 units and holds the input until its last unit enters the single output register.
// A request of zero or one unit is taken every cycle unless out_ready stalls; the next
// request is taken in the cycle its predecessor's last unit enters the output register.
// rst_n is synchronous: it clears the held bytes, the pending plan and out_valid.
// A stalled out_ready holds the output register and the plan; in_ready drops while units remain.
module utf8_decoder_with_error_marker
  import utfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  plan_t plan;
  logic  load;

  assign load = in_valid && in_ready;

  utfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (load),
    .plan    (plan)
  );

  utfd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan),
    .load       (load),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  a_term_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_end |-> out_data.run_last)
    else $error("terminator not marked as last unit of its request");

  a_old_flush_marked: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (plan.vld[SLOT_OLD_MARK] == plan.vld[SLOT_OLD_LEAD]) &&
             (!plan.vld[SLOT_OLD_SECOND] || plan.vld[SLOT_OLD_LEAD]))
    else $error("held-byte flush without marker");

  a_last_flush_then_term: assert property (@(posedge clk) disable iff (!rst_n)
    load && plan.vld[SLOT_LAST_LEAD] |-> plan.vld[SLOT_LAST_MARK] && plan.vld[SLOT_TERM])
    else $error("end-of-string flush not followed by marker and terminator");
`endif

endmodule
